>>> src/modexp_pkg.sv
package modexp_pkg;

  localparam int EXP_BITS = 64;
  localparam int MOD_BITS = 32;

  localparam int EXP_W = 64;
  localparam int CFG_DATA_W = 32;
  localparam int CFG_ADDR_W = 3;

  localparam logic REG_BASE = 1'b0;
  localparam logic REG_MODULUS = 1'b1;

  localparam logic [CFG_DATA_W-1:0] BASE_RESET = 32'd10;
  localparam logic [CFG_DATA_W-1:0] MODULUS_RESET = 32'd1000000;

  typedef struct packed {
    logic                start;
    logic [MOD_BITS-1:0] a;
    logic [MOD_BITS-1:0] b;
    logic [MOD_BITS-1:0] m;
  } mm_req_t;

  typedef struct packed {
    logic                busy;
    logic                done;
    logic [MOD_BITS-1:0] result;
  } mm_rsp_t;

endpackage

>>> src/modexp_mulmod.sv
module modexp_mulmod import modexp_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  mm_req_t req,
  output mm_rsp_t rsp
);

  logic                busy_r, busy_nxt;
  logic [MOD_BITS-1:0] sum_r, sum_nxt;
  logic [MOD_BITS-1:0] addend_r, addend_nxt;
  logic [MOD_BITS-1:0] mult_r, mult_nxt;
  logic [MOD_BITS:0]   sum_ext, dbl_ext, m_ext;
  logic [MOD_BITS:0]   sum_red, dbl_red;
  logic                done;

  assign m_ext   = {1'b0, req.m};
  assign sum_ext = {1'b0, sum_r} + {1'b0, addend_r};
  assign dbl_ext = {addend_r, 1'b0};
  assign sum_red = (sum_ext >= m_ext) ? (sum_ext - m_ext) : sum_ext;
  assign dbl_red = (dbl_ext >= m_ext) ? (dbl_ext - m_ext) : dbl_ext;
  assign done    = busy_r && (mult_r == '0);

  always_comb begin
    busy_nxt   = busy_r;
    sum_nxt    = sum_r;
    addend_nxt = addend_r;
    mult_nxt   = mult_r;
    if (req.start) begin
      busy_nxt   = 1'b1;
      sum_nxt    = '0;
      addend_nxt = req.a;
      mult_nxt   = req.b;
    end else if (done) begin
      busy_nxt = 1'b0;
    end else if (busy_r) begin
      if (mult_r[0]) begin
        sum_nxt = sum_red[MOD_BITS-1:0];
      end
      addend_nxt = dbl_red[MOD_BITS-1:0];
      mult_nxt   = mult_r >> 1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
    end
    sum_r    <= sum_nxt;
    addend_r <= addend_nxt;
    mult_r   <= mult_nxt;
  end

  assign rsp.busy   = busy_r;
  assign rsp.done   = done;
  assign rsp.result = sum_r;

endmodule

>>> src/modular_exponentiation.sv
// Computes base_value ^ exponent mod modulus_value for each exponent transferred on the
// input channel and returns one power_result per item; base and modulus are set through the
// register port (base at 0x0, modulus at 0x4), and a modulus below two yields zero. The user
// must write them only while the block is idle; the block itself does not enforce this. One
// shift-and-add modular multiplier does all the work: it reduces the base once, then forms
// one or two products per exponent bit, each stepping through the significant bits of its
// multiplier. Exponents have 64 bits and the modulus 32; an item stops early once the
// remaining exponent bits are all zero. Input is stalled while an item is in work; a finished
// result sits in an output register, so the next exponent can be taken while it waits.
module modular_exponentiation import modexp_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [EXP_W-1:0]      in_exponent,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [31:0]           out_power_result,
  input  logic                  cfg_psel,
  input  logic                  cfg_penable,
  input  logic                  cfg_pwrite,
  input  logic [CFG_ADDR_W-1:0] cfg_paddr,
  input  logic [CFG_DATA_W-1:0] cfg_pwdata,
  output logic [CFG_DATA_W-1:0] cfg_prdata,
  output logic                  cfg_pready
);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_PREP = 3'd1;
  localparam logic [2:0] ST_BASE = 3'd2;
  localparam logic [2:0] ST_STEP = 3'd3;
  localparam logic [2:0] ST_MUL  = 3'd4;
  localparam logic [2:0] ST_SQR  = 3'd5;
  localparam logic [2:0] ST_DONE = 3'd6;

  logic [2:0]            state_r, state_nxt;
  logic [CFG_DATA_W-1:0] base_r, modulus_r;
  logic [EXP_BITS-1:0]   exp_r, exp_nxt;
  logic [MOD_BITS-1:0]   m_r, m_nxt;
  logic [MOD_BITS-1:0]   sq_r, sq_nxt;
  logic [MOD_BITS-1:0]   prod_r, prod_nxt;
  logic [MOD_BITS-1:0]   res_r, res_nxt;
  logic                  out_valid_r, out_valid_nxt;
  logic [31:0]           out_data_r, out_data_nxt;
  logic                  in_xfer, out_xfer, cfg_wr;
  mm_req_t               mm_req;
  mm_rsp_t               mm_rsp;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign cfg_prdata = (cfg_paddr[2] == REG_MODULUS) ? modulus_r : base_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_r    <= BASE_RESET;
      modulus_r <= MODULUS_RESET;
    end else if (cfg_wr) begin
      unique case (cfg_paddr[2])
        REG_BASE:    base_r <= cfg_pwdata;
        REG_MODULUS: modulus_r <= cfg_pwdata;
        default:     base_r <= base_r;
      endcase
    end
  end

  assign in_stall  = (state_r != ST_IDLE);
  assign in_xfer   = in_valid && !in_stall;
  assign out_valid = out_valid_r;
  assign out_xfer  = out_valid_r && !out_stall;
  assign out_power_result = out_data_r;

  modexp_mulmod u_mulmod (
    .clk  (clk),
    .rst_n(rst_n),
    .req  (mm_req),
    .rsp  (mm_rsp)
  );

  always_comb begin
    state_nxt     = state_r;
    exp_nxt       = exp_r;
    m_nxt         = m_r;
    sq_nxt        = sq_r;
    prod_nxt      = prod_r;
    res_nxt       = res_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    mm_req.start  = 1'b0;
    mm_req.a      = prod_r;
    mm_req.b      = sq_r;
    mm_req.m      = m_r;

    if (out_xfer) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      ST_IDLE: begin
        if (in_xfer) begin
          exp_nxt   = in_exponent[EXP_BITS-1:0];
          m_nxt     = modulus_r[MOD_BITS-1:0];
          state_nxt = ST_PREP;
        end
      end
      ST_PREP: begin
        if (m_r < MOD_BITS'(2)) begin
          res_nxt   = '0;
          state_nxt = ST_DONE;
        end else begin
          mm_req.start = 1'b1;
          mm_req.a     = MOD_BITS'(1);
          mm_req.b     = base_r[MOD_BITS-1:0];
          state_nxt    = ST_BASE;
        end
      end
      ST_BASE: begin
        if (mm_rsp.done) begin
          sq_nxt    = mm_rsp.result;
          prod_nxt  = MOD_BITS'(1);
          state_nxt = ST_STEP;
        end
      end
      ST_STEP: begin
        if (exp_r == '0) begin
          res_nxt   = prod_r;
          state_nxt = ST_DONE;
        end else if (exp_r[0]) begin
          mm_req.start = 1'b1;
          state_nxt    = ST_MUL;
        end else begin
          mm_req.start = 1'b1;
          mm_req.a     = sq_r;
          state_nxt    = ST_SQR;
        end
      end
      ST_MUL: begin
        if (mm_rsp.done) begin
          prod_nxt     = mm_rsp.result;
          mm_req.start = 1'b1;
          mm_req.a     = sq_r;
          state_nxt    = ST_SQR;
        end
      end
      ST_SQR: begin
        if (mm_rsp.done) begin
          sq_nxt    = mm_rsp.result;
          exp_nxt   = exp_r >> 1;
          state_nxt = ST_STEP;
        end
      end
      ST_DONE: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = 32'(res_r);
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
    exp_r      <= exp_nxt;
    m_r        <= m_nxt;
    sq_r       <= sq_nxt;
    prod_r     <= prod_nxt;
    res_r      <= res_nxt;
    out_data_r <= out_data_nxt;
  end

  a_mm_done_in_op: assert property (@(posedge clk) disable iff (!rst_n)
    mm_rsp.done |-> (state_r == ST_BASE || state_r == ST_MUL || state_r == ST_SQR))
    else $error("multiplier finished outside a product state");

  a_mm_idle_when_waiting: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_IDLE || state_r == ST_STEP || state_r == ST_DONE) |-> !mm_rsp.busy)
    else $error("multiplier busy while the sequencer is not waiting on it");

  a_result_reduced: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DONE) |->
      ((m_r < MOD_BITS'(2)) ? (res_r == '0) : (res_r < m_r)))
    else $error("result not reduced modulo the modulus");

  a_operands_reduced: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_STEP) |-> (sq_r < m_r && prod_r < m_r))
    else $error("running square or product not below the modulus");

endmodule
